// File: src/stp_pkg.sv
// Shared types and constants for the software timer pool.
// No dependencies; every other file of the block refers to this package.
package stp_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TICK_W     = 32;
    localparam int CMD_W      = 3;
    localparam int TIDX_W     = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_START   = 3'd1,
        CMD_CHECK   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_WAIT    = 3'd4,
        CMD_RESTART = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        TS_STOPPED = 2'd0,
        TS_RUNNING = 2'd1,
        TS_EXPIRED = 2'd2,
        TS_WAITING = 2'd3
    } t_tstate;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctrl;

endpackage

// File: src/software_timer_pool.sv
// Top level of the software timer pool.
// Depends on stp_pkg, stp_ctrl and stp_datapath.
//
//  Channel   Handshake             Payload
//  -------   --------------------  --------------------------------------------
//  request   i_start / o_busy      i_cmd, i_timer_index, i_timeout_value
//  result    o_done (one cycle)    o_expired, o_timer_state, o_bad_index
//
// Each request is accepted, then executed. In the accept cycle the addressed entry
// is read from the timer store, and in the following execute cycle the entry is
// updated and the result registered. o_busy is high during the execute cycle.
// The result appears on the ports in the cycle after execution, and a new
// request may be accepted in that same cycle, but none while one is executing.
// Reset (i_rst_n low at a clock edge) clears the tick counter and marks every
// timer stopped, disabled and empty at once; no clearing pass is needed.
// The receiver cannot stall results; nothing in the block waits on it.
module software_timer_pool (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [stp_pkg::CMD_W-1:0]  i_cmd,
    input  logic [stp_pkg::TIDX_W-1:0] i_timer_index,
    input  logic [stp_pkg::TICK_W-1:0] i_timeout_value,
    output logic                      o_done,
    output logic                      o_expired,
    output logic [1:0]                o_timer_state,
    output logic                      o_bad_index
);

    // Capture and execute commands from the sequencer to the datapath.
    stp_pkg::t_ctrl ctrl;

    stp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_ctrl  (ctrl)
    );

    // The datapath holds the tick counter, the per-timer store and the result.
    stp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_cmd           (i_cmd),
        .i_timer_index   (i_timer_index),
        .i_timeout_value (i_timeout_value),
        .o_done          (o_done),
        .o_expired       (o_expired),
        .o_timer_state   (o_timer_state),
        .o_bad_index     (o_bad_index)
    );

endmodule

// File: src/stp_ctrl.sv
// Controller of the software timer pool: a two-state sequencer.
// Depends on stp_pkg for the command struct.
module stp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output stp_pkg::t_ctrl o_ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_ctrl.capture = (r_state == ST_IDLE) && i_start;
    assign o_ctrl.exec    = (r_state == ST_EXEC);

    // A captured request is always executed in the very next cycle.
    a_capture_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.capture |=> o_ctrl.exec)
        else $error("captured request not executed next cycle");

    // Execution lasts a single cycle and never overlaps a capture.
    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.exec |-> !o_ctrl.capture ##1 !o_ctrl.exec)
        else $error("execute cycle repeated or overlapped capture");

endmodule

// File: src/stp_datapath.sv
// Datapath of the software timer pool: tick counter, timer store and result registers.
// Depends on stp_pkg; driven by the command struct from stp_ctrl.
module stp_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  stp_pkg::t_ctrl            i_ctrl,
    input  logic [stp_pkg::CMD_W-1:0]  i_cmd,
    input  logic [stp_pkg::TIDX_W-1:0] i_timer_index,
    input  logic [stp_pkg::TICK_W-1:0] i_timeout_value,
    output logic                      o_done,
    output logic                      o_expired,
    output logic [1:0]                o_timer_state,
    output logic                      o_bad_index
);

    localparam int N  = stp_pkg::NUM_TIMERS;
    localparam int IW = stp_pkg::IDX_W;
    localparam int TW = stp_pkg::TICK_W;

    // Stamp (upper half) and timeout (lower half) of each timer.
    logic [2*TW-1:0] mem [N];

    logic                      r_valid [N];
    stp_pkg::t_tstate          r_tstate [N];
    logic                      r_en [N];
    logic [TW-1:0]             r_tick;

    logic [stp_pkg::CMD_W-1:0]  r_cmd;
    logic [stp_pkg::TIDX_W-1:0] r_idx;
    logic [TW-1:0]             r_tmo;
    logic [2*TW-1:0]           r_rd_word;
    logic                      r_rd_valid;

    logic                      r_done;
    logic                      r_expired;
    stp_pkg::t_tstate          r_res_state;
    logic                      r_bad;

    logic [IW-1:0]             rd_addr;
    logic [IW-1:0]             ex_addr;
    logic                      in_range;
    logic [TW-1:0]             cur_stamp;
    logic [TW-1:0]             cur_tmo;
    logic [TW-1:0]             elapsed;
    logic                      elapsed_hit;

    logic                      wr_mem;
    logic [2*TW-1:0]           wr_word;
    logic                      set_valid;
    logic                      clr_valid;
    logic                      upd_entry;
    stp_pkg::t_tstate          new_state;
    logic                      new_en;
    logic                      tick_inc;
    logic                      n_expired;
    stp_pkg::t_tstate          n_res_state;
    logic                      n_bad;

    assign rd_addr   = i_timer_index[IW-1:0];
    assign ex_addr   = r_idx[IW-1:0];
    assign in_range  = ({1'b0, r_idx} < 9'(N));
    assign cur_stamp = r_rd_valid ? r_rd_word[2*TW-1:TW] : '0;
    assign cur_tmo   = r_rd_valid ? r_rd_word[TW-1:0]    : '0;
    assign elapsed   = r_tick - cur_stamp;
    assign elapsed_hit = r_en[ex_addr] && (elapsed >= cur_tmo);

    always_comb begin
        wr_mem      = 1'b0;
        wr_word     = {r_tick, r_tmo};
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        upd_entry   = 1'b0;
        new_state   = r_tstate[ex_addr];
        new_en      = r_en[ex_addr];
        tick_inc    = 1'b0;
        n_expired   = 1'b0;
        n_res_state = stp_pkg::TS_STOPPED;
        n_bad       = 1'b0;
        unique case (stp_pkg::t_cmd'(r_cmd)) inside
            stp_pkg::CMD_TICK: begin
                tick_inc = 1'b1;
            end
            stp_pkg::CMD_START, stp_pkg::CMD_CHECK, stp_pkg::CMD_STOP,
            stp_pkg::CMD_WAIT, stp_pkg::CMD_RESTART: begin
                if (!in_range) begin
                    n_bad = 1'b1;
                end else begin
                    upd_entry = 1'b1;
                    unique case (stp_pkg::t_cmd'(r_cmd))
                        stp_pkg::CMD_START: begin
                            wr_mem    = 1'b1;
                            set_valid = 1'b1;
                            new_state = stp_pkg::TS_RUNNING;
                            new_en    = 1'b1;
                        end
                        stp_pkg::CMD_CHECK: begin
                            if (elapsed_hit) begin
                                new_state = stp_pkg::TS_EXPIRED;
                                n_expired = 1'b1;
                            end
                        end
                        stp_pkg::CMD_STOP: begin
                            clr_valid = 1'b1;
                            new_state = stp_pkg::TS_STOPPED;
                            new_en    = 1'b0;
                        end
                        stp_pkg::CMD_WAIT: begin
                            new_state = stp_pkg::TS_WAITING;
                            new_en    = 1'b0;
                        end
                        default: begin
                            // Restart keeps the stored timeout, zero if the entry was cleared.
                            wr_mem    = 1'b1;
                            wr_word   = {r_tick, cur_tmo};
                            set_valid = 1'b1;
                            new_state = stp_pkg::TS_RUNNING;
                            new_en    = 1'b1;
                        end
                    endcase
                    n_res_state = new_state;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd      <= i_cmd;
            r_idx      <= i_timer_index;
            r_tmo      <= i_timeout_value;
            r_rd_word  <= mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
        end
        if (i_ctrl.exec && wr_mem) begin
            mem[ex_addr] <= wr_word;
        end
        if (i_ctrl.exec) begin
            r_expired   <= n_expired;
            r_res_state <= n_res_state;
            r_bad       <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_done <= 1'b0;
            for (int k = 0; k < N; k++) begin
                r_valid[k]  <= 1'b0;
                r_tstate[k] <= stp_pkg::TS_STOPPED;
                r_en[k]     <= 1'b0;
            end
        end else begin
            r_done <= i_ctrl.exec;
            if (i_ctrl.exec && tick_inc) begin
                r_tick <= r_tick + TW'(1);
            end
            if (i_ctrl.exec && upd_entry) begin
                r_tstate[ex_addr] <= new_state;
                r_en[ex_addr]     <= new_en;
                if (set_valid) begin
                    r_valid[ex_addr] <= 1'b1;
                end else if (clr_valid) begin
                    r_valid[ex_addr] <= 1'b0;
                end
            end
        end
    end

    assign o_done        = r_done;
    assign o_expired     = r_expired;
    assign o_timer_state = r_res_state;
    assign o_bad_index   = r_bad;

    // A result strobe appears in the cycle after each execute cycle.
    a_done_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done == $past(i_ctrl.exec))
        else $error("result strobe not aligned with execute cycle");

    // A flagged index never reports expiry or a nonzero state.
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_bad) |-> (!r_expired && r_res_state == stp_pkg::TS_STOPPED))
        else $error("bad index result carries expiry or state");

    // Expiry is only ever reported together with the expired state.
    a_hit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_expired) |-> (r_res_state == stp_pkg::TS_EXPIRED))
        else $error("expiry reported without expired state");

endmodule
